// ===== rtl/ile_pkg.sv =====
package ile_pkg;

    // Width of one stored element
    localparam int DATA_W = 32;

    // Operation codes of an input item
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_FRONT  = 3'd3,
        ACT_BACK   = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic ins;  // open a slot at the position, later entries move back
        logic rem;  // close the slot at the position, later entries move forward
    } t_cell_ctl;

endpackage

// ===== rtl/indexed_list_engine_top.sv =====
// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   i_action, i_position, i_data_value
// result    out        o_valid, one cycle     o_status, o_read_data, o_element_count
//
// Insert, remove, push and failed items: result in the cycle after accept, and the
// next item may be accepted in that same cycle (one item per cycle sustained).
// A read at a valid position walks the cell read chain: busy is high while the
// walk runs, and the result, taken from the last cell, follows the last walk step.
// Synchronous active-low reset empties the list; stored values stay undefined.
// Results cannot be stalled: o_valid is high for exactly one cycle per item.
module indexed_list_engine_top #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_action,
    input  logic [$clog2(DEPTH+1)-1:0]          i_position,
    input  logic signed [ile_pkg::DATA_W-1:0]   i_data_value,
    output logic                                o_valid,
    output logic [1:0]                          o_status,
    output logic signed [ile_pkg::DATA_W-1:0]   o_read_data,
    output logic [$clog2(DEPTH+1)-1:0]          o_element_count
);
    import ile_pkg::*;

    localparam int             PW        = $clog2(DEPTH + 1);
    localparam int             SW        = $clog2(DEPTH);
    localparam logic [PW-1:0]  LEN_FULL  = PW'(DEPTH);
    localparam logic [SW-1:0]  STEP_LAST = SW'(DEPTH - 1);

    t_state                 r_state, n_state;
    logic [PW-1:0]          r_len;
    logic [PW-1:0]          r_pos;
    logic [SW-1:0]          r_step;
    logic                   r_valid;
    t_status                r_status;
    logic signed [DATA_W-1:0] r_rdata;
    logic                   r_from_chain;

    t_action                act;
    t_status                st_now;
    logic signed [DATA_W-1:0] rd_now;
    logic [PW-1:0]          op_pos;
    logic                   do_ins, do_rem, do_walk;
    logic                   accept, walk_done, len_full;
    t_cell_ctl              c_ctl;
    logic [PW-1:0]          c_pos;

    logic signed [DATA_W-1:0] w_entry [DEPTH];
    logic signed [DATA_W-1:0] w_prev  [DEPTH];
    logic signed [DATA_W-1:0] w_next  [DEPTH];
    logic signed [DATA_W-1:0] w_rdin  [DEPTH];
    logic signed [DATA_W-1:0] w_rd    [DEPTH];

    // Decode the item and check position and fill level
    assign act      = t_action'(i_action);
    assign len_full = (r_len == LEN_FULL);

    always_comb begin
        op_pos  = i_position;
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_walk = 1'b0;
        st_now  = ST_OK;
        rd_now  = '0;
        case (act)
            ACT_INSERT: begin
                if (i_position > r_len) begin
                    st_now = ST_BADPOS;
                end else if (len_full) begin
                    st_now = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ACT_FRONT: begin
                op_pos = '0;
                if (len_full) begin
                    st_now = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ACT_BACK: begin
                op_pos = r_len;
                if (len_full) begin
                    st_now = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (i_position >= r_len) begin
                    st_now = ST_BADPOS;
                end else begin
                    do_rem = 1'b1;
                end
            end
            ACT_READ: begin
                if (i_position >= r_len) begin
                    st_now = ST_BADPOS;
                    rd_now = '1;
                end else begin
                    do_walk = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && do_walk) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_step == STEP_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        busy      = (r_state == S_WALK);
        walk_done = (r_state == S_WALK) && (r_step == STEP_LAST);
    end

    assign accept    = start && !busy;
    assign c_ctl.ins = accept && do_ins;
    assign c_ctl.rem = accept && do_rem;
    assign c_pos     = busy ? r_pos : op_pos;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && !do_walk) || walk_done;
            if (c_ctl.ins) begin
                r_len <= r_len + 1'b1;
            end else if (c_ctl.rem) begin
                r_len <= r_len - 1'b1;
            end
            if (accept) begin
                r_step <= '0;
            end else if (busy) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Result payload, captured at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos        <= i_position;
            r_status     <= st_now;
            r_rdata      <= rd_now;
            r_from_chain <= do_walk;
        end
    end

    // Row of cells, neighbors wired left and right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g] = '0;
            assign w_rdin[g] = '0;
        end else begin : g_mid
            assign w_prev[g] = w_entry[g-1];
            assign w_rdin[g] = w_rd[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_inner
            assign w_next[g] = w_entry[g+1];
        end

        ile_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (c_ctl),
            .i_pos   (c_pos),
            .i_data  (i_data_value),
            .i_prev  (w_prev[g]),
            .i_next  (w_next[g]),
            .i_rd    (w_rdin[g]),
            .o_entry (w_entry[g]),
            .o_rd    (w_rd[g])
        );
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_read_data     = r_from_chain ? w_rd[DEPTH-1] : r_rdata;
    assign o_element_count = r_len;

`ifndef ASSERT_OFF
    // Count never exceeds the number of cells
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_FULL)
        else $error("element count above depth");

    // No result is strobed while a read walk is under way
    a_no_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && busy))
        else $error("result strobe during walk");

    // A good read starts a walk
    a_read_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && do_walk |=> busy && r_step == '0)
        else $error("read did not start walk");

    // The last walk step always yields a strobe from the chain
    a_walk_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        walk_done |=> o_valid && r_from_chain && !busy)
        else $error("walk ended without result");

    // List length holds while walking
    a_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> $stable(r_len))
        else $error("length changed during walk");
`endif

endmodule

// ===== rtl/ile_cell.sv =====
module ile_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  ile_pkg::t_cell_ctl                  i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]          i_pos,
    input  logic signed [ile_pkg::DATA_W-1:0]   i_data,
    input  logic signed [ile_pkg::DATA_W-1:0]   i_prev,
    input  logic signed [ile_pkg::DATA_W-1:0]   i_next,
    input  logic signed [ile_pkg::DATA_W-1:0]   i_rd,
    output logic signed [ile_pkg::DATA_W-1:0]   o_entry,
    output logic signed [ile_pkg::DATA_W-1:0]   o_rd
);
    import ile_pkg::*;

    localparam int             PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]  MY_IDX = PW'(IDX);

    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic signed [DATA_W-1:0] r_rd, n_rd;

    // Entry update: keep the entry, or take the new item, the left neighbor or the right neighbor
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY_IDX == i_pos) begin
                n_entry = i_data;
            end else if (MY_IDX > i_pos) begin
                n_entry = i_prev;
            end
        end else if (i_ctl.rem) begin
            if (MY_IDX >= i_pos) begin
                n_entry = i_next;
            end
        end
    end

    // Read chain: substitute own entry on a position match, else pass along
    always_comb begin
        n_rd = (MY_IDX == i_pos) ? r_entry : i_rd;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_rd    <= n_rd;
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule
